// ===== rtl/core/pkme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkme_pkg
// Shared types, constants, constant tables and saturating helpers of the
// pi-pi K matrix evaluator.
// ----------------------------------------------------------------------------
package pkme_pkg;

  localparam int FRAC    = 24;
  localparam int VW      = 48;
  localparam int RW      = 32;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 4;
  localparam int NBG     = 5;
  localparam int BGW     = 3;
  localparam int MAG_W   = 61;
  localparam int DIV_W   = 36;
  localparam int DIV_STEPS = MAG_W;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [RW-1:0] reg_t;

  typedef struct packed {
    logic flag;
    val_t value;
  } sval_t;

  typedef struct packed {
    logic start;
    val_t a;
    val_t b;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic flag;
    val_t value;
  } unit_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRE_DIV,
    ST_PRE_MUL,
    ST_FAC_DIV,
    ST_COEF_DIV,
    ST_COEF_MUL,
    ST_TERM_DIV,
    ST_TERM_MUL,
    ST_ACC_MUL1,
    ST_ACC_MUL2,
    ST_ACC_WR,
    ST_BG_MUL,
    ST_BG_WR,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_PUSH
  } state_t;

  localparam logic [CFG_W-1:0] REG_SCATTER_OFFSET = CFG_W'(0);
  localparam logic [CFG_W-1:0] REG_ADLER_ZERO     = CFG_W'(1);
  localparam logic [CFG_W-1:0] REG_ADLER_OFFSET   = CFG_W'(2);
  localparam logic [CFG_W-1:0] REG_BG_FIRST       = CFG_W'(3);
  localparam logic [CFG_W-1:0] REG_BG_LAST        = CFG_W'(7);

  localparam reg_t RST_SCATTER_OFFSET = -32'sd55459436;
  localparam reg_t RST_ADLER_ZERO     = 32'sd163409;
  localparam reg_t RST_ADLER_OFFSET   = -32'sd3355443;

  localparam val_t ONE_Q = val_t'(1) <<< FRAC;
  localparam val_t MAXV  = {1'b0, {(VW-1){1'b1}}};
  localparam val_t MINV  = {1'b1, {(VW-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_MAX_POS = {{(MAG_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic [MAG_W-1:0] MAG_MAX_NEG = MAG_MAX_POS + MAG_W'(1);

  function automatic reg_t bg_init(input int c);
    unique case (c)
      0: return 32'sd4476329;
      1: return 32'sd2782166;
      2: return -32'sd3328600;
      3: return 32'sd5504269;
      default: return 32'sd5233317;
    endcase
  endfunction

  function automatic reg_t pole_init(input int p);
    unique case (p)
      0: return 32'sd7110201;
      1: return 32'sd24449971;
      2: return 32'sd40892919;
      3: return 32'sd24667977;
      4: return 32'sd55417843;
      default: return reg_t'(ONE_Q);
    endcase
  endfunction

  function automatic reg_t coup_init(input int p, input int c);
    reg_t r;
    r = '0;
    if (c < 5) begin
      unique case (p)
        0: unique case (c)
             0: r = 32'sd4168132;
             1: r = -32'sd8811897;
             2: r = 32'sd0;
             3: r = -32'sd6522646;
             default: r = -32'sd6106403;
           endcase
        1: unique case (c)
             0: r = 32'sd15397961;
             1: r = 32'sd9299108;
             2: r = 32'sd0;
             3: r = 32'sd6493621;
             default: r = 32'sd4940555;
           endcase
        2: unique case (c)
             0: r = 32'sd6211596;
             1: r = 32'sd3957913;
             2: r = 32'sd10503376;
             3: r = 32'sd3088518;
             default: r = 32'sd3174753;
           endcase
        3: unique case (c)
             0: r = 32'sd5788307;
             1: r = 32'sd6650824;
             2: r = 32'sd16381945;
             3: r = 32'sd3312829;
             default: r = 32'sd59895;
           endcase
        4: unique case (c)
             0: r = 32'sd2645767;
             1: r = -32'sd3005638;
             2: r = -32'sd15116272;
             3: r = -32'sd156196;
             default: r = 32'sd3471038;
           endcase
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic val_t sx(input reg_t x);
    return val_t'(x);
  endfunction

  function automatic logic [VW-1:0] mag48(input val_t x);
    return x[VW-1] ? (~x + VW'(1)) : x;
  endfunction

  function automatic sval_t from_mag(input logic [MAG_W-1:0] mag, input logic neg);
    sval_t r;
    r.flag = 1'b0;
    if (neg) begin
      if (mag > MAG_MAX_NEG) begin
        r.value = MINV;
        r.flag  = 1'b1;
      end else begin
        r.value = -val_t'(mag[VW-1:0]);
      end
    end else if (mag > MAG_MAX_POS) begin
      r.value = MAXV;
      r.flag  = 1'b1;
    end else begin
      r.value = val_t'(mag[VW-1:0]);
    end
    return r;
  endfunction

  function automatic sval_t add_sat(input val_t a, input val_t b, input logic sub);
    logic signed [VW:0] sum;
    sval_t r;
    sum = sub ? ({a[VW-1], a} - {b[VW-1], b}) : ({a[VW-1], a} + {b[VW-1], b});
    r.flag = sum[VW] != sum[VW-1];
    if (r.flag) r.value = sum[VW] ? MINV : MAXV;
    else r.value = sum[VW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/pkme_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkme channel interfaces
// Valid/ready channels for the energy input and the K matrix entry output.
// ----------------------------------------------------------------------------
interface pkme_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] energy_sq;
  logic               times_poles;

  modport source (output valid, output energy_sq, output times_poles, input ready);
  modport sink (input valid, input energy_sq, input times_poles, output ready);
endinterface

interface pkme_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [47:0] entry;
  logic               saturated;
  logic               last;

  modport source (output valid, output row, output col, output entry, output saturated,
                  output last, input ready);
  modport sink (input valid, input row, input col, input entry, input saturated,
                input last, output ready);
endinterface

// ===== rtl/core/pipi_k_matrix_eval_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipi_k_matrix_eval_unit
// Symmetric pi-pi S-wave K matrix evaluator on a shared multiplier and a
// shared bit-serial divider under one sequencer.
//
// Usage: one energy_sq / times_poles transfer on in_ch starts an evaluation;
// out_ch then carries CHANNEL_COUNT^2 entries in row-major order, last set
// on the final one. in_ch.ready is high only while the sequencer is idle.
// An item runs 2*POLE_COUNT+2 divides and about
// CHANNEL_COUNT*(CHANNEL_COUNT+1)*POLE_COUNT + CHANNEL_COUNT^2 + 6 multiplies
// (plus POLE_COUNT^2 more in pole-multiplied mode) on the shared multiplier
// and divider. Results sit in a one-entry output register; a stalled receiver
// holds the sequencer before the next entry. Reset (rst, synchronous) returns
// to idle, drops a pending output and reloads the configuration registers.
// Configuration writes are taken at any cycle but belong in idle time.
// ----------------------------------------------------------------------------
module pipi_k_matrix_eval_unit #(
  parameter int POLE_COUNT    = 5,
  parameter int CHANNEL_COUNT = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [pkme_pkg::CFG_W-1:0] cfg_index,
  input  logic [pkme_pkg::RW-1:0]    cfg_data,
  pkme_in_if.sink                    in_ch,
  pkme_out_if.source                 out_ch
);

  localparam int PW     = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;
  localparam int CW     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int DEPTH  = CHANNEL_COUNT * CHANNEL_COUNT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NBG_EFF = (CHANNEL_COUNT < pkme_pkg::NBG) ? CHANNEL_COUNT : pkme_pkg::NBG;
  localparam int VW     = pkme_pkg::VW;

  pkme_pkg::state_t state;
  pkme_pkg::state_t state_next;

  pkme_pkg::reg_t scatter_offset;
  pkme_pkg::reg_t adler_zero;
  pkme_pkg::reg_t adler_offset;
  pkme_pkg::reg_t bg_coef [pkme_pkg::NBG];

  pkme_pkg::reg_t s;
  logic           mp;
  pkme_pkg::val_t pre;
  logic           pf;
  pkme_pkg::val_t coeff;
  logic           cf;
  pkme_pkg::val_t term;
  logic           tf;
  pkme_pkg::val_t v;
  logic           vf;
  pkme_pkg::val_t fac [POLE_COUNT];
  logic           facf [POLE_COUNT];

  logic [PW-1:0] z;
  logic [PW-1:0] m;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic          launched;

  logic z_last;
  logic m_last;
  logic j_end;
  logic tri_last;
  logic bg_last;
  logic skip;
  logic is_mul;
  logic is_div;
  logic launch;
  logic step;

  pkme_pkg::unit_req_t mul_req;
  pkme_pkg::unit_req_t div_req;
  pkme_pkg::unit_rsp_t mul_rsp;
  pkme_pkg::unit_rsp_t div_rsp;
  logic                unit_done;
  pkme_pkg::val_t      unit_val;
  logic                unit_flag;
  pkme_pkg::val_t      op_a;
  pkme_pkg::val_t      op_b;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [VW:0]   ram_wdata;
  logic [VW:0]   ram_rdata;
  pkme_pkg::val_t rd_val;
  logic           rd_flag;
  logic           use_rd;
  pkme_pkg::sval_t wsum;
  pkme_pkg::sval_t facr;
  logic [CW-1:0]  lo;
  logic [CW-1:0]  hi;
  logic           out_free;

  pkme_pkg::val_t out_value;
  logic           out_flag;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scatter_offset <= pkme_pkg::RST_SCATTER_OFFSET;
      adler_zero     <= pkme_pkg::RST_ADLER_ZERO;
      adler_offset   <= pkme_pkg::RST_ADLER_OFFSET;
      for (int b = 0; b < pkme_pkg::NBG; b++) bg_coef[b] <= pkme_pkg::bg_init(b);
    end else if (cfg_write) begin
      if (cfg_index == pkme_pkg::REG_SCATTER_OFFSET) scatter_offset <= cfg_data;
      else if (cfg_index == pkme_pkg::REG_ADLER_ZERO) adler_zero <= cfg_data;
      else if (cfg_index == pkme_pkg::REG_ADLER_OFFSET) adler_offset <= cfg_data;
      else if (cfg_index >= pkme_pkg::REG_BG_FIRST && cfg_index <= pkme_pkg::REG_BG_LAST) begin
        bg_coef[pkme_pkg::BGW'(cfg_index - pkme_pkg::REG_BG_FIRST)] <= cfg_data;
      end
    end
  end

  // loop bounds
  always_comb begin
    z_last   = z == PW'(POLE_COUNT - 1);
    m_last   = m == PW'(POLE_COUNT - 1);
    j_end    = j == CW'(CHANNEL_COUNT - 1);
    tri_last = (i == CW'(CHANNEL_COUNT - 1)) && j_end;
    bg_last  = j == CW'(NBG_EFF - 1);
    skip     = (state == pkme_pkg::ST_TERM_MUL) && (z == m);
    unit_done = mul_rsp.done | div_rsp.done;
    unit_val  = mul_rsp.done ? mul_rsp.value : div_rsp.value;
    unit_flag = mul_rsp.done ? mul_rsp.flag : div_rsp.flag;
    out_free  = !out_ch.valid || out_ch.ready;
    lo = (i <= j) ? i : j;
    hi = (i <= j) ? j : i;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pkme_pkg::ST_IDLE:     if (in_ch.valid) state_next = pkme_pkg::ST_PRE_DIV;
      pkme_pkg::ST_PRE_DIV:  if (unit_done) state_next = pkme_pkg::ST_PRE_MUL;
      pkme_pkg::ST_PRE_MUL:  if (unit_done) state_next = pkme_pkg::ST_FAC_DIV;
      pkme_pkg::ST_FAC_DIV:  if (unit_done && z_last) state_next = pkme_pkg::ST_COEF_DIV;
      pkme_pkg::ST_COEF_DIV: begin
        if (unit_done) state_next = mp ? pkme_pkg::ST_COEF_MUL : pkme_pkg::ST_TERM_DIV;
      end
      pkme_pkg::ST_COEF_MUL: if (unit_done && z_last) state_next = pkme_pkg::ST_TERM_DIV;
      pkme_pkg::ST_TERM_DIV: begin
        if (unit_done) state_next = mp ? pkme_pkg::ST_TERM_MUL : pkme_pkg::ST_ACC_MUL1;
      end
      pkme_pkg::ST_TERM_MUL: begin
        if ((skip || unit_done) && z_last) state_next = pkme_pkg::ST_ACC_MUL1;
      end
      pkme_pkg::ST_ACC_MUL1: if (unit_done) state_next = pkme_pkg::ST_ACC_MUL2;
      pkme_pkg::ST_ACC_MUL2: if (unit_done) state_next = pkme_pkg::ST_ACC_WR;
      pkme_pkg::ST_ACC_WR: begin
        if (!tri_last) state_next = pkme_pkg::ST_ACC_MUL1;
        else state_next = m_last ? pkme_pkg::ST_BG_MUL : pkme_pkg::ST_TERM_DIV;
      end
      pkme_pkg::ST_BG_MUL:   if (unit_done) state_next = pkme_pkg::ST_BG_WR;
      pkme_pkg::ST_BG_WR:    state_next = bg_last ? pkme_pkg::ST_OUT_RD : pkme_pkg::ST_BG_MUL;
      pkme_pkg::ST_OUT_RD:   state_next = pkme_pkg::ST_OUT_MUL;
      pkme_pkg::ST_OUT_MUL:  if (unit_done) state_next = pkme_pkg::ST_OUT_PUSH;
      pkme_pkg::ST_OUT_PUSH: begin
        if (out_free) state_next = tri_last ? pkme_pkg::ST_IDLE : pkme_pkg::ST_OUT_RD;
      end
      default: state_next = pkme_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: unit operands, launches, accumulator port
  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    op_a   = '0;
    op_b   = '0;
    unique case (state)
      pkme_pkg::ST_PRE_DIV: begin
        is_div = 1'b1;
        op_a = pkme_pkg::ONE_Q - pkme_pkg::sx(adler_offset);
        op_b = pkme_pkg::sx(s) - pkme_pkg::sx(adler_offset);
      end
      pkme_pkg::ST_PRE_MUL: begin
        is_mul = 1'b1;
        op_a = pkme_pkg::sx(s) - pkme_pkg::sx(adler_zero);
        op_b = pre;
      end
      pkme_pkg::ST_FAC_DIV: begin
        is_div = 1'b1;
        op_a = pkme_pkg::sx(s);
        op_b = pkme_pkg::sx(pkme_pkg::pole_init(int'(z)));
      end
      pkme_pkg::ST_COEF_DIV: begin
        is_div = 1'b1;
        op_a = pkme_pkg::ONE_Q - pkme_pkg::sx(scatter_offset);
        op_b = pkme_pkg::sx(s) - pkme_pkg::sx(scatter_offset);
      end
      pkme_pkg::ST_COEF_MUL: begin
        is_mul = 1'b1;
        op_a = coeff;
        op_b = fac[z];
      end
      pkme_pkg::ST_TERM_DIV: begin
        is_div = 1'b1;
        op_a = pkme_pkg::ONE_Q;
        op_b = mp ? pkme_pkg::sx(pkme_pkg::pole_init(int'(m)))
                  : pkme_pkg::sx(pkme_pkg::pole_init(int'(m))) - pkme_pkg::sx(s);
      end
      pkme_pkg::ST_TERM_MUL: begin
        is_mul = 1'b1;
        op_a = term;
        op_b = fac[z];
      end
      pkme_pkg::ST_ACC_MUL1: begin
        is_mul = 1'b1;
        op_a = term;
        op_b = pkme_pkg::sx(pkme_pkg::coup_init(int'(m), int'(i)));
      end
      pkme_pkg::ST_ACC_MUL2: begin
        is_mul = 1'b1;
        op_a = v;
        op_b = pkme_pkg::sx(pkme_pkg::coup_init(int'(m), int'(j)));
      end
      pkme_pkg::ST_BG_MUL: begin
        is_mul = 1'b1;
        op_a = coeff;
        op_b = pkme_pkg::sx(bg_coef[pkme_pkg::BGW'(j)]);
      end
      pkme_pkg::ST_OUT_MUL: begin
        is_mul = 1'b1;
        op_a = rd_val;
        op_b = pre;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
    launch = (is_mul || is_div) && !launched && !skip;
    mul_req.start = launch && is_mul;
    mul_req.a = op_a;
    mul_req.b = op_b;
    div_req.start = launch && is_div;
    div_req.a = op_a;
    div_req.b = op_b;

    in_ch.ready = state == pkme_pkg::ST_IDLE;

    if (state == pkme_pkg::ST_OUT_RD || state == pkme_pkg::ST_OUT_MUL ||
        state == pkme_pkg::ST_OUT_PUSH) begin
      ram_addr = AW'(lo) * AW'(CHANNEL_COUNT) + AW'(hi);
    end else begin
      ram_addr = AW'(i) * AW'(CHANNEL_COUNT) + AW'(j);
    end
    rd_val  = ram_rdata[VW-1:0];
    rd_flag = ram_rdata[VW];
    use_rd  = (state == pkme_pkg::ST_BG_WR) || (m != '0);
    wsum    = pkme_pkg::add_sat(use_rd ? rd_val : '0, v, 1'b0);
    ram_we  = (state == pkme_pkg::ST_ACC_WR) || (state == pkme_pkg::ST_BG_WR);
    ram_wdata = {vf | wsum.flag | (use_rd & rd_flag), wsum.value};
    facr    = pkme_pkg::add_sat(pkme_pkg::ONE_Q, unit_val, 1'b1);
    step    = unit_done || skip;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pkme_pkg::ST_IDLE;
      launched <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (unit_done) launched <= 1'b0;
      else if (launch) launched <= 1'b1;
      if (state == pkme_pkg::ST_OUT_PUSH && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  // datapath registers and loop counters
  always_ff @(posedge clk) begin
    unique case (state)
      pkme_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          s  <= in_ch.energy_sq;
          mp <= in_ch.times_poles;
          z  <= '0;
          m  <= '0;
          i  <= '0;
          j  <= '0;
        end
      end
      pkme_pkg::ST_PRE_DIV: begin
        if (unit_done) begin
          pre <= unit_val;
          pf  <= unit_flag;
        end
      end
      pkme_pkg::ST_PRE_MUL: begin
        if (unit_done) begin
          pre <= unit_val;
          pf  <= pf | unit_flag;
        end
      end
      pkme_pkg::ST_FAC_DIV: begin
        if (unit_done) begin
          fac[z]  <= facr.value;
          facf[z] <= unit_flag | facr.flag;
          z <= z_last ? '0 : z + PW'(1);
        end
      end
      pkme_pkg::ST_COEF_DIV: begin
        if (unit_done) begin
          coeff <= unit_val;
          cf    <= unit_flag;
        end
      end
      pkme_pkg::ST_COEF_MUL: begin
        if (unit_done) begin
          coeff <= unit_val;
          cf    <= cf | facf[z] | unit_flag;
          z <= z_last ? '0 : z + PW'(1);
        end
      end
      pkme_pkg::ST_TERM_DIV: begin
        if (unit_done) begin
          term <= unit_val;
          tf   <= unit_flag;
        end
      end
      pkme_pkg::ST_TERM_MUL: begin
        if (unit_done) begin
          term <= unit_val;
          tf   <= tf | facf[z] | unit_flag;
        end
        if (step) z <= z_last ? '0 : z + PW'(1);
      end
      pkme_pkg::ST_ACC_MUL1: begin
        if (unit_done) begin
          v  <= unit_val;
          vf <= tf | unit_flag;
        end
      end
      pkme_pkg::ST_ACC_MUL2: begin
        if (unit_done) begin
          v  <= unit_val;
          vf <= vf | unit_flag;
        end
      end
      pkme_pkg::ST_ACC_WR: begin
        if (tri_last) begin
          i <= '0;
          j <= '0;
          m <= m_last ? '0 : m + PW'(1);
        end else if (j_end) begin
          i <= i + CW'(1);
          j <= i + CW'(1);
        end else begin
          j <= j + CW'(1);
        end
      end
      pkme_pkg::ST_BG_MUL: begin
        if (unit_done) begin
          v  <= unit_val;
          vf <= cf | unit_flag;
        end
      end
      pkme_pkg::ST_BG_WR: begin
        j <= bg_last ? '0 : j + CW'(1);
      end
      pkme_pkg::ST_OUT_MUL: begin
        if (unit_done) begin
          out_value <= unit_val;
          out_flag  <= rd_flag | pf | unit_flag;
        end
      end
      pkme_pkg::ST_OUT_PUSH: begin
        if (out_free) begin
          out_ch.row       <= pkme_pkg::IDX_W'(i);
          out_ch.col       <= pkme_pkg::IDX_W'(j);
          out_ch.entry     <= out_value;
          out_ch.saturated <= out_flag;
          out_ch.last      <= tri_last;
          if (tri_last) begin
            i <= '0;
            j <= '0;
          end else if (j_end) begin
            i <= i + CW'(1);
            j <= '0;
          end else begin
            j <= j + CW'(1);
          end
        end
      end
      default: begin
        v <= v;
      end
    endcase
  end

  pkme_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  pkme_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pkme_ram #(
    .WIDTH (VW + 1),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/pkme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkme_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 25
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pkme_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkme_mul
// Q23.24 multiplier: four 24x24 partial products on one multiplier,
// rounded to nearest, ties away from zero, saturated.
// ----------------------------------------------------------------------------
module pkme_mul (
  input  logic                clk,
  input  logic                rst,
  input  pkme_pkg::unit_req_t req,
  output pkme_pkg::unit_rsp_t rsp
);

  logic [47:0] ua;
  logic [47:0] ub;
  logic        neg;
  logic        big;
  logic        busy;
  logic [2:0]  k;
  logic [47:0] prod;
  logic [50:0] acc;
  logic [23:0] xa;
  logic [23:0] xb;
  logic [47:0] product;
  pkme_pkg::sval_t fin;
  logic            done;
  logic            flag;
  pkme_pkg::val_t  value;

  assign rsp = {done, flag, value};

  always_comb begin
    xa = (k < 3'd2) ? ua[47:24] : ua[23:0];
    xb = (k == 3'd0 || k == 3'd2) ? ub[47:24] : ub[23:0];
    product = xa * xb;
    fin = pkme_pkg::from_mag(pkme_pkg::MAG_W'(acc), neg);
    if (big) begin
      fin.value = neg ? pkme_pkg::MINV : pkme_pkg::MAXV;
      fin.flag  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        k    <= 3'd0;
      end else if (busy) begin
        k <= k + 3'd1;
        if (k == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua  <= pkme_pkg::mag48(req.a);
      ub  <= pkme_pkg::mag48(req.b);
      neg <= req.a[47] != req.b[47];
      big <= 1'b0;
      acc <= '0;
    end else if (busy) begin
      if (k < 3'd4) prod <= product;
      unique case (k)
        3'd1: begin
          big <= prod[47:24] != 24'd0;
          acc <= acc + 51'({prod[23:0], 24'd0});
        end
        3'd2, 3'd3: acc <= acc + 51'(prod);
        3'd4: acc <= acc + 51'((prod + 48'h80_0000) >> 24);
        default: acc <= acc;
      endcase
      if (k == 3'd5) begin
        value <= fin.value;
        flag  <= fin.flag;
      end
    end
  end

endmodule

// ===== rtl/core/pkme_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkme_div
// Restoring divider, one quotient bit per cycle, Q23.24 result rounded to
// nearest, ties away from zero; divide by zero saturates.
// ----------------------------------------------------------------------------
module pkme_div (
  input  logic                clk,
  input  logic                rst,
  input  pkme_pkg::unit_req_t req,
  output pkme_pkg::unit_rsp_t rsp
);

  localparam int CNT_W = $clog2(pkme_pkg::DIV_STEPS);

  logic                          busy;
  logic                          fin;
  logic [CNT_W-1:0]              cnt;
  logic [pkme_pkg::MAG_W-1:0]    dvd;
  logic [pkme_pkg::MAG_W-1:0]    q;
  logic [pkme_pkg::DIV_W-1:0]    rem;
  logic [pkme_pkg::DIV_W-1:0]    ud;
  logic                          neg;
  logic [pkme_pkg::DIV_W:0]      rem_sh;
  logic                          ge;
  logic [pkme_pkg::DIV_W-1:0]    un_in;
  logic [pkme_pkg::DIV_W-1:0]    ud_in;
  pkme_pkg::sval_t               res;
  logic                          done;
  logic                          flag;
  pkme_pkg::val_t                value;

  assign rsp = {done, flag, value};

  always_comb begin
    rem_sh = {rem, dvd[pkme_pkg::MAG_W-1]};
    ge     = rem_sh >= {1'b0, ud};
    un_in  = pkme_pkg::DIV_W'(pkme_pkg::mag48(req.a));
    ud_in  = pkme_pkg::DIV_W'(pkme_pkg::mag48(req.b));
    res    = pkme_pkg::from_mag(q, neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (req.start) begin
        busy <= req.b != '0;
        done <= req.b == '0;
      end else if (busy && cnt == CNT_W'(pkme_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt   <= '0;
      rem   <= '0;
      q     <= '0;
      ud    <= ud_in;
      neg   <= req.a[47] != req.b[47];
      dvd   <= pkme_pkg::MAG_W'({un_in, 24'd0}) + pkme_pkg::MAG_W'(ud_in >> 1);
      value <= req.a[47] ? pkme_pkg::MINV : pkme_pkg::MAXV;
      flag  <= 1'b1;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      rem <= ge ? pkme_pkg::DIV_W'(rem_sh - {1'b0, ud}) : rem_sh[pkme_pkg::DIV_W-1:0];
      q   <= {q[pkme_pkg::MAG_W-2:0], ge};
      dvd <= dvd << 1;
    end else if (fin) begin
      value <= res.value;
      flag  <= res.flag;
    end
  end

endmodule

// ===== rtl/core/pkme_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkme_checker
// Port-level checks of the K matrix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pkme_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_row,
  input logic [2:0]  out_col,
  input logic [47:0] out_entry,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_entry) && $stable(out_row))
    else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_no_accept_mid_matrix: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready before the matrix is done");

  a_last_on_diagonal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_row == out_col)
    else $error("last entry off the diagonal");

endmodule

bind pipi_k_matrix_eval_unit pkme_checker u_pkme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.row),
  .out_col   (out_ch.col),
  .out_entry (out_ch.entry),
  .out_last  (out_ch.last)
);
